// ===== sv/tnon_pkg.sv =====
// shared types and codes for the telnet option negotiator
`default_nettype none

package tnon_pkg;

    // item modes
    localparam logic [1:0] MODE_BYTE      = 2'd0;
    localparam logic [1:0] MODE_EN_LOCAL  = 2'd1;
    localparam logic [1:0] MODE_EN_REMOTE = 2'd2;

    // telnet command bytes
    localparam logic [7:0] B_SB   = 8'd250;
    localparam logic [7:0] B_WILL = 8'd251;
    localparam logic [7:0] B_DONT = 8'd254;
    localparam logic [7:0] B_IAC  = 8'd255;

    // reply verbs
    localparam logic [1:0] VERB_WILL = 2'd0;
    localparam logic [1:0] VERB_WONT = 2'd1;
    localparam logic [1:0] VERB_DO   = 2'd2;
    localparam logic [1:0] VERB_DONT = 2'd3;

    typedef struct packed {
        logic       data_valid;
        logic [7:0] data;
        logic       neg_valid;
        logic [1:0] verb;
    } parse_res_t;

    typedef enum logic [1:0] {
        QOP_NONE,
        QOP_NEG,
        QOP_EN_LOCAL,
        QOP_EN_REMOTE
    } qop_t;

    typedef struct packed {
        qop_t       op;
        logic [1:0] verb;
        logic [7:0] option;
    } qreq_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] command;
        logic [7:0] option;
    } qrsp_t;

endpackage

`default_nettype wire

// ===== sv/telnet_option_negotiator_core.sv =====
// top level of the telnet option negotiator
`default_nettype none

// Accepts one transaction per cycle: a received telnet byte (mode 0) or a
// request to enable a local (mode 1) or remote (mode 2) option. Each item is
// resolved by the byte parser and the q-method option table while it sits in
// the input register, giving zero or one result that is registered into the
// output register when the item is processed. Throughput is one item per
// cycle while the output side does not stall; a stalled result holds the
// item behind it and then stalls the input. Results are data bytes (kind 0)
// or negotiation replies (kind 1); options at or above NUM_OPTIONS are
// refused and enable requests for them are ignored.

module telnet_option_negotiator_core
    import tnon_pkg::*;
#(
    parameter int NUM_OPTIONS = 4
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [1:0] mode,
    input  wire logic [7:0] byte_value,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic            kind,
    output logic [7:0]      data_byte,
    output logic [1:0]      reply_command,
    output logic [7:0]      reply_option
);

    logic       in_valid_reg;
    logic [1:0] mode_reg;
    logic [7:0] byte_reg;

    logic       out_valid_reg;
    logic       kind_reg;
    logic [7:0] data_reg;
    logic [1:0] cmd_reg;
    logic [7:0] opt_reg;

    logic       in_accept, proc_fire;
    parse_res_t parse_res;
    qreq_t      qreq;
    qrsp_t      qrsp;

    assign proc_fire = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !proc_fire;
    assign in_accept = in_valid && !in_stall;

    tnon_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (proc_fire && (mode_reg == MODE_BYTE)),
        .byte_value (byte_reg),
        .res        (parse_res)
    );

    always_comb
    begin
        qreq.op     = QOP_NONE;
        qreq.verb   = parse_res.verb;
        qreq.option = byte_reg;
        if (parse_res.neg_valid)
        begin
            qreq.op = QOP_NEG;
        end
        else if (proc_fire && (mode_reg == MODE_EN_LOCAL))
        begin
            qreq.op = QOP_EN_LOCAL;
        end
        else if (proc_fire && (mode_reg == MODE_EN_REMOTE))
        begin
            qreq.op = QOP_EN_REMOTE;
        end
    end

    tnon_qtable #(
        .NUM_OPTIONS (NUM_OPTIONS)
    ) u_qtable (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (qreq),
        .rsp   (qrsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (proc_fire)
            begin
                in_valid_reg <= 1'b0;
            end
            if (proc_fire)
            begin
                out_valid_reg <= parse_res.data_valid || qrsp.valid;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            mode_reg <= mode;
            byte_reg <= byte_value;
        end
        if (proc_fire)
        begin
            kind_reg <= qrsp.valid;
            data_reg <= parse_res.data_valid ? parse_res.data : 8'd0;
            cmd_reg  <= qrsp.command;
            opt_reg  <= qrsp.option;
        end
    end

    assign out_valid     = out_valid_reg;
    assign kind          = kind_reg;
    assign data_byte     = data_reg;
    assign reply_command = cmd_reg;
    assign reply_option  = opt_reg;

endmodule

`default_nettype wire

// ===== sv/tnon_parser.sv =====
// telnet byte stream parser: strips iac commands and subnegotiation
`default_nettype none

module tnon_parser
    import tnon_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       fire,
    input  wire logic [7:0] byte_value,
    output parse_res_t      res
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_IAC   = 3'd1,
        ST_OPT   = 3'd2,
        ST_SB    = 3'd3,
        ST_SBIAC = 3'd4
    } pstate_t;

    pstate_t    state_reg, state_next;
    logic [1:0] verb_reg, verb_next;

    always_comb
    begin
        state_next = state_reg;
        verb_next  = verb_reg;
        res        = '0;
        unique case (state_reg)
            ST_IAC:
            begin
                if (byte_value == B_SB)
                begin
                    state_next = ST_SB;
                end
                else if (byte_value >= B_WILL && byte_value <= B_DONT)
                begin
                    verb_next  = 2'(byte_value - B_WILL);
                    state_next = ST_OPT;
                end
                else
                begin
                    state_next = ST_IDLE;
                    // escaped 255 goes up as data
                    if (byte_value == B_IAC)
                    begin
                        res.data_valid = 1'b1;
                        res.data       = byte_value;
                    end
                end
            end
            ST_OPT:
            begin
                state_next    = ST_IDLE;
                res.neg_valid = 1'b1;
                res.verb      = verb_reg;
            end
            ST_SB:
            begin
                if (byte_value == B_IAC)
                begin
                    state_next = ST_SBIAC;
                end
            end
            ST_SBIAC:
            begin
                state_next = (byte_value == B_IAC) ? ST_SB : ST_IDLE;
            end
            default:
            begin
                if (byte_value == B_IAC)
                begin
                    state_next = ST_IAC;
                end
                else
                begin
                    state_next     = ST_IDLE;
                    res.data_valid = 1'b1;
                    res.data       = byte_value;
                end
            end
        endcase
        if (!fire)
        begin
            state_next = state_reg;
            verb_next  = verb_reg;
            res        = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            verb_reg  <= VERB_WILL;
        end
        else
        begin
            state_reg <= state_next;
            verb_reg  <= verb_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/tnon_qtable.sv =====
// per-option q-method negotiation table for the local and remote sides
`default_nettype none

module tnon_qtable
    import tnon_pkg::*;
#(
    parameter int NUM_OPTIONS = 4
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  qreq_t     req,
    output qrsp_t     rsp
);

    localparam int IDX_W = (NUM_OPTIONS > 1) ? $clog2(NUM_OPTIONS) : 1;

    typedef enum logic [2:0] {
        Q_NO      = 3'd0,
        Q_WNO_E   = 3'd1,
        Q_WNO_O   = 3'd2,
        Q_WYES_E  = 3'd3,
        Q_WYES_O  = 3'd4,
        Q_YES     = 3'd5
    } q_state_t;

    typedef struct packed {
        q_state_t   state;
        logic       reply;
        logic [1:0] verb;
    } q_upd_t;

    // peer sent WILL or DO
    function automatic q_upd_t q_positive(q_state_t st, logic wanted,
                                          logic [1:0] yes_v, logic [1:0] no_v);
        q_upd_t u;
        u.state = st;
        u.reply = 1'b0;
        u.verb  = no_v;
        case (st)
            Q_NO:
            begin
                u.reply = 1'b1;
                if (wanted)
                begin
                    u.state = Q_YES;
                    u.verb  = yes_v;
                end
            end
            Q_WNO_E:  u.state = Q_NO;
            Q_WNO_O:  u.state = Q_YES;
            Q_WYES_E: u.state = Q_YES;
            Q_WYES_O:
            begin
                u.state = Q_WNO_E;
                u.reply = 1'b1;
            end
            default:  u.state = st;
        endcase
        return u;
    endfunction

    // peer sent WONT or DONT
    function automatic q_upd_t q_negative(q_state_t st,
                                          logic [1:0] yes_v, logic [1:0] no_v);
        q_upd_t u;
        u.state = st;
        u.reply = 1'b0;
        u.verb  = no_v;
        case (st)
            Q_WNO_E, Q_WYES_E, Q_WYES_O: u.state = Q_NO;
            Q_WNO_O:
            begin
                u.state = Q_WYES_E;
                u.reply = 1'b1;
                u.verb  = yes_v;
            end
            Q_YES:
            begin
                u.state = Q_NO;
                u.reply = 1'b1;
            end
            default: u.state = st;
        endcase
        return u;
    endfunction

    function automatic q_upd_t q_enable(q_state_t st, logic [1:0] verb);
        q_upd_t u;
        u.state = st;
        u.reply = 1'b0;
        u.verb  = verb;
        case (st)
            Q_NO:
            begin
                u.state = Q_WYES_E;
                u.reply = 1'b1;
            end
            Q_WNO_E:  u.state = Q_WNO_O;
            Q_WYES_O: u.state = Q_WYES_E;
            default:  u.state = st;
        endcase
        return u;
    endfunction

    q_state_t   loc_state_reg [NUM_OPTIONS];
    logic       loc_want_reg  [NUM_OPTIONS];
    q_state_t   rem_state_reg [NUM_OPTIONS];
    logic       rem_want_reg  [NUM_OPTIONS];

    logic [IDX_W-1:0] idx;
    logic             in_range;
    q_upd_t           upd;
    logic             loc_we, rem_we, set_want;

    assign idx      = req.option[IDX_W-1:0];
    assign in_range = ({1'b0, req.option} < 9'(NUM_OPTIONS));

    always_comb
    begin
        upd      = '{state: Q_NO, reply: 1'b0, verb: VERB_WILL};
        loc_we   = 1'b0;
        rem_we   = 1'b0;
        set_want = 1'b0;
        unique case (req.op)
            QOP_NEG:
            begin
                if (!in_range)
                begin
                    // options outside the table are always refused
                    upd.reply = (req.verb == VERB_WILL) || (req.verb == VERB_DO);
                    upd.verb  = (req.verb == VERB_WILL) ? VERB_DONT : VERB_WONT;
                end
                else
                begin
                    unique case (req.verb)
                        VERB_WILL:
                        begin
                            upd    = q_positive(rem_state_reg[idx], rem_want_reg[idx],
                                                VERB_DO, VERB_DONT);
                            rem_we = 1'b1;
                        end
                        VERB_WONT:
                        begin
                            upd    = q_negative(rem_state_reg[idx], VERB_DO, VERB_DONT);
                            rem_we = 1'b1;
                        end
                        VERB_DO:
                        begin
                            upd    = q_positive(loc_state_reg[idx], loc_want_reg[idx],
                                                VERB_WILL, VERB_WONT);
                            loc_we = 1'b1;
                        end
                        default:
                        begin
                            upd    = q_negative(loc_state_reg[idx], VERB_WILL, VERB_WONT);
                            loc_we = 1'b1;
                        end
                    endcase
                end
            end
            QOP_EN_LOCAL:
            begin
                if (in_range)
                begin
                    upd      = q_enable(loc_state_reg[idx], VERB_WILL);
                    loc_we   = 1'b1;
                    set_want = upd.reply;
                end
            end
            QOP_EN_REMOTE:
            begin
                if (in_range)
                begin
                    upd      = q_enable(rem_state_reg[idx], VERB_DO);
                    rem_we   = 1'b1;
                    set_want = upd.reply;
                end
            end
            default:
            begin
                upd.reply = 1'b0;
            end
        endcase
    end

    assign rsp.valid   = upd.reply;
    assign rsp.command = upd.reply ? upd.verb : 2'd0;
    assign rsp.option  = upd.reply ? req.option : 8'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_OPTIONS; i++)
            begin
                loc_state_reg[i] <= Q_NO;
                loc_want_reg[i]  <= 1'b0;
                rem_state_reg[i] <= Q_NO;
                rem_want_reg[i]  <= 1'b0;
            end
        end
        else
        begin
            if (loc_we)
            begin
                loc_state_reg[idx] <= upd.state;
                if (set_want)
                begin
                    loc_want_reg[idx] <= 1'b1;
                end
            end
            if (rem_we)
            begin
                rem_state_reg[idx] <= upd.state;
                if (set_want)
                begin
                    rem_want_reg[idx] <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/tnon_checker.sv =====
// port-level assertions for the telnet option negotiator, bound to the top
`default_nettype none

module tnon_checker
    import tnon_pkg::*;
#(
    parameter int NUM_OPTIONS = 4
)
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_stall,
    input wire logic [1:0] mode,
    input wire logic [7:0] byte_value,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic       kind,
    input wire logic [7:0] data_byte,
    input wire logic [1:0] reply_command,
    input wire logic [7:0] reply_option
);

    // a stalled input transaction keeps its payload
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(mode) && $stable(byte_value))
        else $error("stalled input changed");

    // a held result transaction keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(kind) && $stable(data_byte)
            && $stable(reply_command) && $stable(reply_option))
        else $error("stalled result changed");

    // input side only backs up once a result is waiting
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty output");

    // unused fields of a result are zero
    a_fields_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (kind ? (data_byte == 8'd0)
                            : ((reply_command == 2'd0) && (reply_option == 8'd0))))
        else $error("unused result field not zero");

    // options outside the table only ever get refused
    a_refuse_far: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind && ({1'b0, reply_option} >= 9'(NUM_OPTIONS))
            |-> (reply_command == VERB_WONT) || (reply_command == VERB_DONT))
        else $error("option outside table was accepted");

endmodule

bind telnet_option_negotiator_core tnon_checker #(.NUM_OPTIONS(NUM_OPTIONS)) u_tnon_checker (.*);

`default_nettype wire
